FILE: rtl/morton_order_point_sort_macros.svh
// assertion macros included by the top rtl file
`ifndef MORTON_ORDER_POINT_SORT_MACROS_SVH
`define MORTON_ORDER_POINT_SORT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define MOPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define MOPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mops_pkg.sv
// ----------------------------------------------------------------------------
// mops_pkg
// Types, constants and helper functions of the morton order point sort.
// ----------------------------------------------------------------------------
package mops_pkg;

    localparam int MAX_POINTS = 64;
    localparam int GRID_BITS  = 21;
    localparam int COORD_W    = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CODE_W     = 3 * GRID_BITS;
    localparam int OUT_IDX_W  = 6;
    localparam int OUT_CODE_W = 63;
    localparam int SPAN_W     = COORD_W + 1;
    localparam int DVD_W      = SPAN_W + GRID_BITS;
    localparam int STEP_W     = $clog2(GRID_BITS + 1);
    localparam int PT_W       = 3 * COORD_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic                      last_point;
    } t_point;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]  point_index;
        logic [OUT_CODE_W-1:0] sort_code;
        logic                  last_result;
        logic                  dropped;
    } t_result;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GRID_RD,
        S_GRID_START,
        S_GRID_WAIT,
        S_RANK_RD,
        S_RANK_LD,
        S_RANK_SCAN,
        S_OUT_ORD,
        S_OUT_IDX,
        S_OUT_CODE,
        S_OUT_HOLD
    } t_state;

    // bit interleave: x to 3i, y to 3i+1, z to 3i+2
    function automatic logic [CODE_W-1:0] morton(input logic [GRID_BITS-1:0] gx,
                                                 input logic [GRID_BITS-1:0] gy,
                                                 input logic [GRID_BITS-1:0] gz);
        logic [CODE_W-1:0] c;
        c = '0;
        for (int i = 0; i < GRID_BITS; i++) begin
            c[3*i]     = gx[i];
            c[3*i + 1] = gy[i];
            c[3*i + 2] = gz[i];
        end
        return c;
    endfunction

endpackage

FILE: rtl/mops_ram.sv
// ----------------------------------------------------------------------------
// mops_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mops_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mops_grid.sv
// ----------------------------------------------------------------------------
// mops_grid
// One axis of grid mapping: floor(off * (2^GRID_BITS - 1) / span), one
// quotient bit per cycle by restoring division, zero on a flat axis.
// ----------------------------------------------------------------------------
module mops_grid (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [mops_pkg::COORD_W-1:0] i_coord,
    input  logic signed [mops_pkg::COORD_W-1:0] i_lo,
    input  logic signed [mops_pkg::COORD_W-1:0] i_hi,
    output logic                               o_done,
    output logic [mops_pkg::GRID_BITS-1:0]     o_grid
);
    import mops_pkg::*;

    logic [SPAN_W-1:0]    w_off;
    logic [SPAN_W-1:0]    w_span;
    logic [DVD_W-1:0]     w_dvd;
    logic [SPAN_W:0]      w_trial;
    logic                 w_ge;

    logic [SPAN_W-1:0]    r_rem;
    logic [GRID_BITS-1:0] r_low;
    logic [GRID_BITS-1:0] r_q;
    logic [SPAN_W-1:0]    r_span;
    logic                 r_flat;
    logic [STEP_W-1:0]    r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // offset and span, both non-negative in 33 bits
    assign w_off  = {i_coord[COORD_W-1], i_coord} - {i_lo[COORD_W-1], i_lo};
    assign w_span = {i_hi[COORD_W-1], i_hi} - {i_lo[COORD_W-1], i_lo};
    // off * (2^GRID_BITS - 1) as shift and subtract
    assign w_dvd  = (DVD_W'(w_off) << GRID_BITS) - DVD_W'(w_off);

    // one restoring step
    assign w_trial = {r_rem, r_low[GRID_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_span};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(GRID_BITS - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == '0);
            r_busy <= (r_cnt != '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_dvd[DVD_W-1:GRID_BITS];
            r_low  <= w_dvd[GRID_BITS-1:0];
            r_q    <= '0;
            r_span <= w_span;
            r_flat <= (w_span == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? SPAN_W'(w_trial - {1'b0, r_span}) : w_trial[SPAN_W-1:0];
            r_low <= r_low << 1;
            r_q   <= {r_q[GRID_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_grid = r_flat ? '0 : r_q;

endmodule

FILE: rtl/morton_order_point_sort.sv
// ----------------------------------------------------------------------------
// morton_order_point_sort
// Loads a 3D point set, maps it to a grid over its bounding box, and returns
// the point indices in ascending Morton code order.
// ----------------------------------------------------------------------------
// Points load at one per cycle while o_in_ready is high. After the point marked
// last_point the block stops taking points and works on the stored set of n
// points: it maps each point to the grid in the three per-axis divider lanes,
// then ranks each code by a scan of the code memory through its single read
// port, then returns the results in order, each held until it is taken.
// Ties in code go to the lower arrival index. Points beyond 64 are dropped,
// and every result of that set carries dropped.
module morton_order_point_sort (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mops_pkg::t_point  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mops_pkg::t_result o_out_data
);
    import mops_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_ovf, n_ovf;
    logic signed [COORD_W-1:0] r_min [3];
    logic signed [COORD_W-1:0] r_max [3];
    logic signed [COORD_W-1:0] n_min [3];
    logic signed [COORD_W-1:0] n_max [3];
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [IDX_W-1:0]          r_jd, n_jd;
    logic [IDX_W-1:0]          r_rank, n_rank;
    logic [IDX_W-1:0]          r_oidx, n_oidx;
    logic [CODE_W-1:0]         r_ci, n_ci;
    t_result                   r_out, n_out;

    logic signed [COORD_W-1:0] w_pt [3];
    logic                      w_in_acc;
    logic                      w_out_acc;
    logic [CNT_W-1:0]          w_last_cnt;
    logic                      w_at_last;
    logic                      w_less;
    logic                      w_start;
    logic [2:0]                w_done;
    logic [GRID_BITS-1:0]      w_grid [3];

    logic                      coord_we;
    logic [IDX_W-1:0]          coord_waddr, coord_raddr;
    logic [PT_W-1:0]           coord_wdata, coord_rdata;
    logic                      code_we;
    logic [IDX_W-1:0]          code_waddr, code_raddr;
    logic [CODE_W-1:0]         code_wdata, code_rdata;
    logic                      ord_we;
    logic [IDX_W-1:0]          ord_waddr, ord_raddr;
    logic [IDX_W-1:0]          ord_wdata, ord_rdata;

    assign w_pt[0]    = i_in_data.x_coord;
    assign w_pt[1]    = i_in_data.y_coord;
    assign w_pt[2]    = i_in_data.z_coord;
    assign o_in_ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT_HOLD);
    assign o_out_data  = r_out;
    assign w_out_acc  = o_out_valid && i_out_ready;
    assign w_last_cnt = r_count - 1'b1;
    assign w_at_last  = (r_idx == w_last_cnt[IDX_W-1:0]);
    // code[j] sorts before code[i]: smaller, or equal with lower index
    assign w_less     = (code_rdata < r_ci) || ((code_rdata == r_ci) && (r_jd < r_idx));

    // point coordinates
    mops_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_coord_ram (
        .i_clk     (i_clk),
        .i_wr_en   (coord_we),
        .i_wr_addr (coord_waddr),
        .i_wr_data (coord_wdata),
        .i_rd_addr (coord_raddr),
        .o_rd_data (coord_rdata)
    );

    // morton codes
    mops_ram #(.WIDTH(CODE_W), .DEPTH(MAX_POINTS)) u_code_ram (
        .i_clk     (i_clk),
        .i_wr_en   (code_we),
        .i_wr_addr (code_waddr),
        .i_wr_data (code_wdata),
        .i_rd_addr (code_raddr),
        .o_rd_data (code_rdata)
    );

    // sorted arrival indices
    mops_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ord_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ord_we),
        .i_wr_addr (ord_waddr),
        .i_wr_data (ord_wdata),
        .i_rd_addr (ord_raddr),
        .o_rd_data (ord_rdata)
    );

    // three divider lanes, one per axis, started together
    for (genvar a = 0; a < 3; a++) begin : g_axis
        mops_grid u_grid (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_coord (coord_rdata[PT_W-1-a*COORD_W -: COORD_W]),
            .i_lo    (r_min[a]),
            .i_hi    (r_max[a]),
            .o_done  (w_done[a]),
            .o_grid  (w_grid[a])
        );
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= {1'b0, {(COORD_W-1){1'b1}}};
                r_max[a] <= {1'b1, {(COORD_W-1){1'b0}}};
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= n_min[a];
                r_max[a] <= n_max[a];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_jd   <= n_jd;
        r_rank <= n_rank;
        r_oidx <= n_oidx;
        r_ci   <= n_ci;
        r_out  <= n_out;
    end

    // next state, memory control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        for (int a = 0; a < 3; a++) begin
            n_min[a] = r_min[a];
            n_max[a] = r_max[a];
        end
        n_idx  = r_idx;
        n_jd   = r_jd;
        n_rank = r_rank;
        n_oidx = r_oidx;
        n_ci   = r_ci;
        n_out  = r_out;

        w_start     = 1'b0;
        coord_we    = 1'b0;
        coord_waddr = r_count[IDX_W-1:0];
        coord_wdata = {i_in_data.x_coord, i_in_data.y_coord, i_in_data.z_coord};
        coord_raddr = r_idx;
        code_we     = 1'b0;
        code_waddr  = r_idx;
        code_wdata  = morton(w_grid[0], w_grid[1], w_grid[2]);
        code_raddr  = r_idx;
        ord_we      = 1'b0;
        ord_waddr   = IDX_W'(r_rank + IDX_W'(w_less));
        ord_wdata   = r_idx;
        ord_raddr   = r_idx;

        unique case (r_state)
            // store points and track the box
            S_LOAD: begin
                if (w_in_acc) begin
                    if (r_count < CNT_W'(MAX_POINTS)) begin
                        coord_we = 1'b1;
                        n_count  = r_count + 1'b1;
                        for (int a = 0; a < 3; a++) begin
                            if (w_pt[a] < r_min[a]) n_min[a] = w_pt[a];
                            if (w_pt[a] > r_max[a]) n_max[a] = w_pt[a];
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_point) begin
                        n_idx   = '0;
                        n_state = S_GRID_RD;
                    end
                end
            end
            // coordinate read issued at r_idx
            S_GRID_RD: begin
                n_state = S_GRID_START;
            end
            S_GRID_START: begin
                w_start = 1'b1;
                n_state = S_GRID_WAIT;
            end
            // write the code when the lanes finish
            S_GRID_WAIT: begin
                if (w_done[0]) begin
                    code_we = 1'b1;
                    if (w_at_last) begin
                        n_idx   = '0;
                        n_state = S_RANK_RD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_GRID_RD;
                    end
                end
            end
            // code of point i read at r_idx
            S_RANK_RD: begin
                n_state = S_RANK_LD;
            end
            S_RANK_LD: begin
                n_ci        = code_rdata;
                code_raddr  = '0;
                n_jd        = '0;
                n_rank      = '0;
                n_state     = S_RANK_SCAN;
            end
            // count codes that sort before point i
            S_RANK_SCAN: begin
                code_raddr = r_jd + 1'b1;
                n_rank     = r_rank + IDX_W'(w_less);
                n_jd       = r_jd + 1'b1;
                if (r_jd == w_last_cnt[IDX_W-1:0]) begin
                    ord_we = 1'b1;
                    if (w_at_last) begin
                        n_idx   = '0;
                        n_state = S_OUT_ORD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RANK_RD;
                    end
                end
            end
            // order entry read at r_idx
            S_OUT_ORD: begin
                n_state = S_OUT_IDX;
            end
            S_OUT_IDX: begin
                code_raddr = ord_rdata;
                n_oidx     = ord_rdata;
                n_state    = S_OUT_CODE;
            end
            S_OUT_CODE: begin
                n_out.point_index = OUT_IDX_W'(r_oidx);
                n_out.sort_code   = OUT_CODE_W'(code_rdata);
                n_out.last_result = w_at_last;
                n_out.dropped     = r_ovf;
                n_state           = S_OUT_HOLD;
            end
            // hold the result until taken
            S_OUT_HOLD: begin
                if (w_out_acc) begin
                    if (r_out.last_result) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            n_min[a] = {1'b0, {(COORD_W-1){1'b1}}};
                            n_max[a] = {1'b1, {(COORD_W-1){1'b0}}};
                        end
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_OUT_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `include "morton_order_point_sort_macros.svh"

    `MOPS_ASSERT_SAME(a_count_cap, 1'b1, r_count <= CNT_W'(MAX_POINTS), "count past capacity")
    `MOPS_ASSERT_SAME(a_lanes_agree, w_done[0], w_done[1] && w_done[2] && r_state == S_GRID_WAIT, "divider lanes out of step")
    `MOPS_ASSERT_NEXT(a_set_cleared, w_out_acc && r_out.last_result, r_count == '0 && !r_ovf && o_in_ready, "set not cleared")
    `MOPS_ASSERT_SAME(a_busy_sorting, r_state != S_LOAD && r_state != S_OUT_HOLD, r_count != '0 && !o_in_ready, "sort without points")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Directed point sets and sets of random size and shape are loaded into the Morton sort block.
// A scoreboard rebuilds the grid codes and the stable sorted order of each set
// and compares every returned index, code and flag in order.
// ----------------------------------------------------------------------------
module tb_top;
    import mops_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    // scoreboard: collects each set and predicts its sorted results
    class morton_scoreboard;
        int xs[$], ys[$], zs[$];
        bit overflow;
        t_result pending[$];
        int errors;
        int sets;
        int results_seen;

        function logic [62:0] grid_code(longint px, longint py, longint pz,
                                        longint lo[3], longint hi[3]);
            longint p[3];
            logic [62:0] c;
            logic [20:0] g[3];
            longint gmax;
            p[0] = px; p[1] = py; p[2] = pz;
            gmax = (64'd1 << 21) - 1;
            for (int a = 0; a < 3; a++) begin
                if (hi[a] <= lo[a]) g[a] = '0;
                else g[a] = 21'(((p[a] - lo[a]) * gmax) / (hi[a] - lo[a]));
            end
            c = '0;
            for (int i = 0; i < 21; i++) begin
                c[3*i] = g[0][i];
                c[3*i+1] = g[1][i];
                c[3*i+2] = g[2][i];
            end
            return c;
        endfunction

        function void note_point(t_point pt);
            longint lo[3], hi[3];
            logic [62:0] codes[$];
            int ord[$];
            int n, j, k;
            t_result r;
            if (xs.size() < MAX_POINTS) begin
                xs.insert(xs.size(), int'(pt.x_coord));
                ys.insert(ys.size(), int'(pt.y_coord));
                zs.insert(zs.size(), int'(pt.z_coord));
            end else begin
                overflow = 1;
            end
            if (!pt.last_point) return;
            n = xs.size();
            for (int a = 0; a < 3; a++) begin
                lo[a] = 64'sd2147483647;
                hi[a] = -64'sd2147483648;
            end
            for (int i = 0; i < n; i++) begin
                if (xs[i] < lo[0]) lo[0] = xs[i];
                if (xs[i] > hi[0]) hi[0] = xs[i];
                if (ys[i] < lo[1]) lo[1] = ys[i];
                if (ys[i] > hi[1]) hi[1] = ys[i];
                if (zs[i] < lo[2]) lo[2] = zs[i];
                if (zs[i] > hi[2]) hi[2] = zs[i];
            end
            for (int i = 0; i < n; i++)
                codes.insert(codes.size(), grid_code(xs[i], ys[i], zs[i], lo, hi));
            // stable insertion of each index behind equal codes
            for (int i = 0; i < n; i++) begin
                k = ord.size();
                for (j = 0; j < ord.size(); j++)
                    if (codes[ord[j]] > codes[i]) begin
                        k = j;
                        break;
                    end
                ord.insert(k, i);
            end
            for (int i = 0; i < n; i++) begin
                r.point_index = ord[i][5:0];
                r.sort_code = codes[ord[i]];
                r.last_result = (i == n - 1);
                r.dropped = overflow;
                pending.insert(pending.size(), r);
            end
            xs.delete(); ys.delete(); zs.delete();
            overflow = 0;
            sets++;
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result index %0d", got.point_index);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.point_index !== exp_r.point_index) begin
                $error("point_index exp %0d got %0d", exp_r.point_index, got.point_index);
                errors++;
            end
            if (got.sort_code !== exp_r.sort_code) begin
                $error("sort_code exp %h got %h", exp_r.sort_code, got.sort_code);
                errors++;
            end
            if (got.last_result !== exp_r.last_result) begin
                $error("last_result exp %0d got %0d", exp_r.last_result, got.last_result);
                errors++;
            end
            if (got.dropped !== exp_r.dropped) begin
                $error("dropped exp %0d got %0d", exp_r.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    i_in_valid = 0;
    logic    o_in_ready;
    t_point  i_in_data = '0;
    logic    o_out_valid;
    logic    i_out_ready = 0;
    t_result o_out_data;

    morton_scoreboard sb = new();
    int idle_cycles;
    int points_sent;
    int out_gap;
    bit timed_out;

    morton_order_point_sort uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: accept results with random stalls, a few of them long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_data);
            if (out_gap > 0) begin
                i_out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else if ($urandom_range(0, 99) < 30) begin
                i_out_ready <= 1'b0;
                out_gap <= gap_len();
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("FAILURE");
            $finish;
        end
    end

    // send one point, wait for its transaction, then an optional gap
    task automatic send_point(input int x, input int y, input int z, input bit last,
                              input bit use_gap);
        int g;
        i_in_data <= '{x_coord: x, y_coord: y, z_coord: z, last_point: last};
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_point('{x_coord: x, y_coord: y, z_coord: z, last_point: last});
        points_sent++;
        g = use_gap ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // random set; shape picks the value style
    task automatic send_set(input int n, input bit use_gap);
        int shape, x, y, z, base;
        shape = $urandom_range(0, 3);
        base = $urandom;
        for (int i = 0; i < n; i++) begin
            x = $urandom; y = $urandom; z = $urandom;
            case (shape)
                1: begin
                    x = base + $urandom_range(0, 7);
                    y = base - $urandom_range(0, 7);
                    z = base;
                end
                2: begin
                    x = $urandom_range(0, 3) * 1000;
                    y = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                end
                default: ;
            endcase
            send_point(x, y, z, i == n - 1, use_gap);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: single point, extremes, flat axis, ties
        send_point(5, -5, 0, 1, 0);
        send_point(32'h80000000, 32'h7fffffff, 0, 0, 0);
        send_point(32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_point(0, 0, 0, 0, 0);
        send_point(32'h7fffffff, 32'h80000000, 0, 1, 0);
        send_point(-1, -1, -1, 0, 0);
        send_point(1, 1, 1, 0, 0);
        send_point(1, 1, 1, 1, 0);
        drain();

        // over capacity: a set of 70, then a set of 65 whose last point alone is dropped
        send_set(70, 0);
        drain();
        for (int i = 0; i < 65; i++)
            send_point($urandom, $urandom, $urandom, i == 64, 0);

        // random sets of mostly small size
        while (points_sent < 250) begin
            if ($urandom_range(0, 9) == 0) send_set(64, $urandom_range(0, 1));
            else send_set($urandom_range(1, 12), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) drain();
        end
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d points in %0d sets, %0d results checked",
                 points_sent, sb.sets, sb.results_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: morton_order_point_sort.f
+incdir+rtl
rtl/mops_pkg.sv
rtl/mops_ram.sv
rtl/mops_grid.sv
rtl/morton_order_point_sort.sv
dv/tb_top.sv
